// ===== design/mbe_pkg.sv =====
package mbe_pkg;

	// Fixed-point format and view geometry.
	localparam int FRAC_BITS = 24;
	localparam int WIDTH     = 800;
	localparam int HEIGHT    = 600;
	localparam int MAX_ITER  = 100;

	localparam int COORD_W   = 11;
	localparam int COUNT_W   = 8;
	localparam int ROM_DEPTH = 2 ** COUNT_W;
	localparam int IDX_W     = COORD_W + 2;

	// Derived datapath widths.
	localparam int OPND_W = 33;
	localparam int PROD_W = 2 * OPND_W;
	localparam int STEP_W = 62 - FRAC_BITS;
	localparam int SQ_W   = 63 - FRAC_BITS;
	localparam int XY_W   = 64 - FRAC_BITS;
	localparam int SUM_W  = XY_W + 2;
	localparam int WIDE_W = 56;

	localparam logic signed [31:0] CENTER_X_RST   = -32'sd9227469;
	localparam logic signed [31:0] CENTER_Y_RST   = 32'sd0;
	localparam logic [30:0]        ZOOM_SCALE_RST = 31'd16777216;
	localparam logic [30:0]        PIXEL_STEP_RST = 31'd55924;
	localparam logic [30:0]        ESCAPE_R2_RST  = 31'd1677721600;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_ZOOM_SCALE = 3'd2,
		REG_PIXEL_STEP = 3'd3,
		REG_ESCAPE_R2  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_STEP_WB,
		ST_MAPX,
		ST_MAPX_WB,
		ST_MAPY,
		ST_MAPY_WB,
		ST_SQR,
		ST_UPD,
		ST_COLOUR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [OPND_W-1:0] a0;
		logic signed [OPND_W-1:0] b0;
		logic signed [OPND_W-1:0] a1;
		logic signed [OPND_W-1:0] b1;
		logic signed [OPND_W-1:0] a2;
		logic signed [OPND_W-1:0] b2;
	} mul_in_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] p0;
		logic signed [PROD_W-1:0] p1;
		logic signed [PROD_W-1:0] p2;
	} mul_out_t;

	// Sine polynomial coefficients, Q30.
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint SIN_C1  = 64'sd1686629713;
	localparam longint SIN_C3  = 64'sd693598668;
	localparam longint SIN_C5  = 64'sd85569305;
	localparam longint SIN_C7  = 64'sd5026996;
	localparam longint SIN_C9  = 64'sd172272;

	localparam logic [63:0] MAX_ITER_L = 64'(MAX_ITER);

	function automatic logic signed [31:0] sat32(logic signed [WIDE_W-1:0] v);
		if (v > 56'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -56'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// One colour component of a Q0.32 phase in turns.
	function automatic logic [7:0] colour_comp(logic [31:0] phase);
		logic [1:0]  quad;
		longint      f;
		longint      u;
		longint      u2;
		longint      acc;
		longint      s;
		logic [63:0] v;
		quad = phase[31:30];
		f    = longint'({34'd0, phase[29:0]});
		u    = quad[0] ? Q30_ONE - f : f;
		u2   = (u * u) >>> 30;
		acc  = SIN_C9;
		acc  = SIN_C7 - ((acc * u2) >>> 30);
		acc  = SIN_C5 - ((acc * u2) >>> 30);
		acc  = SIN_C3 - ((acc * u2) >>> 30);
		acc  = SIN_C1 - ((acc * u2) >>> 30);
		s    = (acc * u) >>> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		if (quad[1]) begin
			s = -s;
		end
		v = 64'(Q30_ONE + s);
		v = (v * 64'd255) >> 31;
		return v[7:0];
	endfunction

	// Packed {red, green, blue} for iteration count n.
	function automatic logic [23:0] colour_entry(logic [COUNT_W-1:0] n);
		logic [63:0] qr;
		logic [63:0] qg;
		logic [63:0] qb;
		qr = ((64'(n) * 64'd4) << 32) / MAX_ITER_L;
		qg = ((64'(n) * 64'd8) << 32) / MAX_ITER_L;
		qb = ((64'(n) * 64'd16) << 32) / MAX_ITER_L;
		return {colour_comp(32'(qr + 64'h2000_0000)),
			colour_comp(32'(qg + 64'h1000_0000)),
			colour_comp(32'(qb + 64'h0800_0000))};
	endfunction

endpackage

// ===== design/mbe_ifs.sv =====
interface mbe_pix_if;
	logic        valid;
	logic        ready;
	logic [10:0] col;
	logic [10:0] row;

	modport source (output valid, output col, output row, input ready);
	modport sink (input valid, input col, input row, output ready);
endinterface

interface mbe_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] iter_count;
	logic       escaped;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output iter_count, output escaped, output red,
		output green, output blue, input ready);
	modport sink (input valid, input iter_count, input escaped, input red,
		input green, input blue, output ready);
endinterface

interface mbe_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mbe_mul3.sv =====
module mbe_mul3 (
	input  logic               clk,
	input  mbe_pkg::mul_in_t   opnd,
	output mbe_pkg::mul_out_t  prod_s1
);

	// Three signed multipliers shared by pixel mapping and the iteration loop.
	always_ff @(posedge clk) begin
		prod_s1.p0 <= opnd.a0 * opnd.b0;
		prod_s1.p1 <= opnd.a1 * opnd.b1;
		prod_s1.p2 <= opnd.a2 * opnd.b2;
	end

endmodule

// ===== design/mbe_colour_rom.sv =====
module mbe_colour_rom (
	input  logic                         clk,
	input  logic [mbe_pkg::COUNT_W-1:0]  addr,
	output logic [23:0]                  data_q
);

	logic [23:0] rom_w [mbe_pkg::ROM_DEPTH];

	for (genvar i = 0; i < mbe_pkg::ROM_DEPTH; i++) begin : g_ent
		localparam logic [23:0] ENT = mbe_pkg::colour_entry(mbe_pkg::COUNT_W'(i));
		assign rom_w[i] = ENT;
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

endmodule

// ===== design/mandelbrot_escape_time_pixel_core.sv =====
// Mandelbrot escape-time pixel core.
// A request on the pixel channel carries one (col, row) position. The core maps it
// to a point c of the complex plane from the view registers, iterates z = z*z + c
// from z = c, and returns one request on the result channel with the iteration
// count, an escaped flag and an RGB colour (black when the point never escapes).
// The cfg channel writes the view registers by index; it is always ready and
// writes are expected only while the core is idle. Unknown indexes are ignored.
// A pixel passes through the step computation, the mapping of x and y, one
// square-and-update loop per escape test (1 to MAX_ITER tests) and the colour lookup.
// Each iteration makes one pass through the shared three-multiplier unit, and the
// escape compare and saturating update follow in the cycle after it.
// One pixel is in flight at a time; pixel.ready is high only while idle, so a new
// pixel is taken only after the previous one has been handed to the output register.
// A finished result sits in an output register, so the next pixel is accepted
// while a stalled receiver still holds the previous result; the core then waits
// at the end of that pixel until the output register frees up.
// Reset puts the view registers at their defaults and empties the core.
module mandelbrot_escape_time_pixel_core (
	input  logic          clk,
	input  logic          arst_n,
	mbe_pix_if.sink       pixel,
	mbe_res_if.source     result,
	mbe_cfg_if.sink       cfg
);

	mbe_pkg::state_t state_q;
	mbe_pkg::state_t state_d;

	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic [30:0]        zoom_scale_q;
	logic [30:0]        pixel_step_q;
	logic [30:0]        escape_r2_q;

	logic [mbe_pkg::COORD_W-1:0] col_q;
	logic [mbe_pkg::COORD_W-1:0] row_q;
	logic [mbe_pkg::STEP_W-1:0]  step_q;
	logic signed [31:0]          cx_q;
	logic signed [31:0]          cy_q;
	logic signed [31:0]          x_q;
	logic signed [31:0]          y_q;
	logic [mbe_pkg::COUNT_W-1:0] n_q;
	logic                        esc_q;

	logic                        res_valid_q;
	logic [mbe_pkg::COUNT_W-1:0] res_count_q;
	logic                        res_esc_q;
	logic [23:0]                 res_rgb_q;

	mbe_pkg::mul_in_t  opnd;
	mbe_pkg::mul_out_t prod_s1;
	logic [23:0]       rom_q;

	logic pix_accept;
	logic out_load;

	logic [mbe_pkg::COORD_W-1:0]     coord_w;
	logic [mbe_pkg::IDX_W-1:0]       size_w;
	logic signed [mbe_pkg::IDX_W-1:0] idx_w;
	logic signed [mbe_pkg::WIDE_W-1:0] off_w;
	logic signed [31:0]               center_w;
	logic signed [31:0]               c_w;

	logic [mbe_pkg::SQ_W-1:0]          x2_w;
	logic [mbe_pkg::SQ_W-1:0]          y2_w;
	logic signed [mbe_pkg::XY_W-1:0]   xy_w;
	logic [mbe_pkg::SQ_W:0]            mag_w;
	logic                              esc_w;
	logic signed [mbe_pkg::SUM_W-1:0]  nx_w;
	logic signed [mbe_pkg::SUM_W-1:0]  ny_w;

	mbe_mul3 u_mul (
		.clk     (clk),
		.opnd    (opnd),
		.prod_s1 (prod_s1)
	);

	mbe_colour_rom u_rom (
		.clk    (clk),
		.addr   (n_q),
		.data_q (rom_q)
	);

	assign pixel.ready = (state_q == mbe_pkg::ST_IDLE);
	assign pix_accept  = pixel.valid && pixel.ready;
	assign cfg.ready   = 1'b1;
	assign out_load    = (state_q == mbe_pkg::ST_FIN) && (!res_valid_q || result.ready);

	// Pixel mapping: (2*index - size) times the step, split into a low and a high
	// partial product so each fits the 33-bit multiplier lanes.
	assign coord_w  = (state_q == mbe_pkg::ST_MAPX) ? col_q : row_q;
	assign size_w   = (state_q == mbe_pkg::ST_MAPX) ? mbe_pkg::IDX_W'(mbe_pkg::WIDTH)
		: mbe_pkg::IDX_W'(mbe_pkg::HEIGHT);
	assign idx_w    = {1'b0, coord_w, 1'b0} - size_w;
	assign off_w    = mbe_pkg::WIDE_W'(prod_s1.p0) + (mbe_pkg::WIDE_W'(prod_s1.p1) <<< 32);
	assign center_w = (state_q == mbe_pkg::ST_MAPX_WB) ? center_x_q : center_y_q;
	assign c_w      = mbe_pkg::sat32(mbe_pkg::WIDE_W'(center_w) + (off_w >>> 1));

	// Iteration update from the registered squares and cross product.
	assign x2_w  = prod_s1.p0[mbe_pkg::FRAC_BITS +: mbe_pkg::SQ_W];
	assign y2_w  = prod_s1.p1[mbe_pkg::FRAC_BITS +: mbe_pkg::SQ_W];
	assign xy_w  = prod_s1.p2[mbe_pkg::FRAC_BITS +: mbe_pkg::XY_W];
	assign mag_w = {1'b0, x2_w} + {1'b0, y2_w};
	assign esc_w = mag_w > (mbe_pkg::SQ_W + 1)'(escape_r2_q);
	assign nx_w  = mbe_pkg::SUM_W'(x2_w) - mbe_pkg::SUM_W'(y2_w) + mbe_pkg::SUM_W'(cx_q);
	assign ny_w  = (mbe_pkg::SUM_W'(xy_w) <<< 1) + mbe_pkg::SUM_W'(cy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		opnd    = '0;
		unique case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (pix_accept) begin
					state_d = mbe_pkg::ST_STEP;
				end
			end
			mbe_pkg::ST_STEP: begin
				opnd.a0 = mbe_pkg::OPND_W'(zoom_scale_q);
				opnd.b0 = mbe_pkg::OPND_W'(pixel_step_q);
				state_d = mbe_pkg::ST_STEP_WB;
			end
			mbe_pkg::ST_STEP_WB: begin
				state_d = mbe_pkg::ST_MAPX;
			end
			mbe_pkg::ST_MAPX, mbe_pkg::ST_MAPY: begin
				opnd.a0 = mbe_pkg::OPND_W'(idx_w);
				opnd.b0 = {1'b0, step_q[31:0]};
				opnd.a1 = mbe_pkg::OPND_W'(idx_w);
				opnd.b1 = mbe_pkg::OPND_W'(step_q[mbe_pkg::STEP_W-1:32]);
				state_d = (state_q == mbe_pkg::ST_MAPX) ? mbe_pkg::ST_MAPX_WB
					: mbe_pkg::ST_MAPY_WB;
			end
			mbe_pkg::ST_MAPX_WB: begin
				state_d = mbe_pkg::ST_MAPY;
			end
			mbe_pkg::ST_MAPY_WB: begin
				state_d = mbe_pkg::ST_SQR;
			end
			mbe_pkg::ST_SQR: begin
				opnd.a0 = mbe_pkg::OPND_W'(x_q);
				opnd.b0 = mbe_pkg::OPND_W'(x_q);
				opnd.a1 = mbe_pkg::OPND_W'(y_q);
				opnd.b1 = mbe_pkg::OPND_W'(y_q);
				opnd.a2 = mbe_pkg::OPND_W'(x_q);
				opnd.b2 = mbe_pkg::OPND_W'(y_q);
				state_d = mbe_pkg::ST_UPD;
			end
			mbe_pkg::ST_UPD: begin
				if (esc_w || (n_q == mbe_pkg::COUNT_W'(mbe_pkg::MAX_ITER - 1))) begin
					state_d = mbe_pkg::ST_COLOUR;
				end else begin
					state_d = mbe_pkg::ST_SQR;
				end
			end
			mbe_pkg::ST_COLOUR: begin
				state_d = mbe_pkg::ST_FIN;
			end
			mbe_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = mbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	// View registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= mbe_pkg::CENTER_X_RST;
			center_y_q   <= mbe_pkg::CENTER_Y_RST;
			zoom_scale_q <= mbe_pkg::ZOOM_SCALE_RST;
			pixel_step_q <= mbe_pkg::PIXEL_STEP_RST;
			escape_r2_q  <= mbe_pkg::ESCAPE_R2_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				mbe_pkg::REG_CENTER_X:   center_x_q   <= cfg.data;
				mbe_pkg::REG_CENTER_Y:   center_y_q   <= cfg.data;
				mbe_pkg::REG_ZOOM_SCALE: zoom_scale_q <= cfg.data[30:0];
				mbe_pkg::REG_PIXEL_STEP: pixel_step_q <= cfg.data[30:0];
				mbe_pkg::REG_ESCAPE_R2:  escape_r2_q  <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	// Loop control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			esc_q <= 1'b0;
		end else if (pix_accept) begin
			n_q   <= '0;
			esc_q <= 1'b0;
		end else if (state_q == mbe_pkg::ST_UPD) begin
			if (esc_w) begin
				esc_q <= 1'b1;
			end else begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			col_q <= pixel.col;
			row_q <= pixel.row;
		end
		if (state_q == mbe_pkg::ST_STEP_WB) begin
			step_q <= prod_s1.p0[mbe_pkg::FRAC_BITS +: mbe_pkg::STEP_W];
		end
		if (state_q == mbe_pkg::ST_MAPX_WB) begin
			cx_q <= c_w;
			x_q  <= c_w;
		end
		if (state_q == mbe_pkg::ST_MAPY_WB) begin
			cy_q <= c_w;
			y_q  <= c_w;
		end
		if ((state_q == mbe_pkg::ST_UPD) && !esc_w) begin
			x_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(nx_w));
			y_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(ny_w));
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_count_q <= n_q;
			res_esc_q   <= esc_q;
			res_rgb_q   <= esc_q ? rom_q : 24'd0;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.iter_count = res_count_q;
	assign result.escaped    = res_esc_q;
	assign result.red        = res_rgb_q[23:16];
	assign result.green      = res_rgb_q[15:8];
	assign result.blue       = res_rgb_q[7:0];

	// A new pixel always starts with the step computation.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept |=> (state_q == mbe_pkg::ST_STEP))
		else $error("pixel acceptance did not start the sequencer");

	// A non-escaping test advances the count by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mbe_pkg::ST_UPD) && !esc_w) |=> (n_q == $past(n_q) + 1'b1))
		else $error("iteration count did not advance");

	// Escaped results count below the limit; others are black at the limit.
	a_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result.escaped
			? (result.iter_count < mbe_pkg::COUNT_W'(mbe_pkg::MAX_ITER))
			: ((result.iter_count == mbe_pkg::COUNT_W'(mbe_pkg::MAX_ITER))
				&& (result.red == 8'd0) && (result.green == 8'd0)
				&& (result.blue == 8'd0))))
		else $error("result count or colour inconsistent with escape flag");

endmodule

// ===== tb/sv/escape_time_checker.sv =====
module escape_time_checker (
	input  logic      clk,
	input  logic      arst_n,
	mbe_pix_if        pixel,
	mbe_res_if        result,
	mbe_cfg_if        cfg,
	output int        mismatches,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint POLY_C1 = 64'sd1686629713;
	localparam longint POLY_C3 = 64'sd693598668;
	localparam longint POLY_C5 = 64'sd85569305;
	localparam longint POLY_C7 = 64'sd5026996;
	localparam longint POLY_C9 = 64'sd172272;
	localparam longint Q32_MAX = 64'sd2147483647;
	localparam longint Q32_MIN = -64'sd2147483648;

	typedef struct {
		logic [7:0] iter_count;
		logic       escaped;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_colour_t;

	// View registers as the core should hold them.
	longint view_cx;
	longint view_cy;
	longint view_zoom;
	longint view_step;
	longint view_r2;

	pixel_colour_t expected_pixels[$];

	function automatic longint clamp_q32(longint v);
		if (v > Q32_MAX) begin
			return Q32_MAX;
		end else if (v < Q32_MIN) begin
			return Q32_MIN;
		end
		return v;
	endfunction

	// Sine of a phase given in turns (Q0.32), returned in Q30.
	function automatic longint sine_turn(logic [31:0] phase);
		longint f;
		longint u;
		longint u2;
		longint acc;
		longint s;
		f   = longint'(phase[29:0]);
		u   = phase[30] ? ONE_Q30 - f : f;
		u2  = (u * u) >>> 30;
		acc = POLY_C9;
		acc = POLY_C7 - ((acc * u2) >>> 30);
		acc = POLY_C5 - ((acc * u2) >>> 30);
		acc = POLY_C3 - ((acc * u2) >>> 30);
		acc = POLY_C1 - ((acc * u2) >>> 30);
		s   = (acc * u) >>> 30;
		if (s > ONE_Q30) begin
			s = ONE_Q30;
		end
		return phase[31] ? -s : s;
	endfunction

	function automatic logic [7:0] gradient_level(logic [7:0] n, logic [63:0] k,
		logic [31:0] offs);
		logic [63:0] q;
		logic [31:0] phase;
		longint      v;
		q     = ((64'(n) * k) << 32) / 64'(mbe_pkg::MAX_ITER);
		phase = q[31:0] + offs;
		v     = ONE_Q30 + sine_turn(phase);
		v     = (v * 64'sd255) >>> 31;
		return v[7:0];
	endfunction

	function automatic pixel_colour_t escape_time(logic [10:0] col, logic [10:0] row);
		pixel_colour_t r;
		longint        step;
		longint        cx;
		longint        cy;
		longint        x;
		longint        y;
		longint        x2;
		longint        y2;
		longint        xy;
		int            n;
		bit            gone;
		step = (view_zoom * view_step) >>> mbe_pkg::FRAC_BITS;
		cx   = clamp_q32(view_cx
			+ ((((2 * longint'(col)) - mbe_pkg::WIDTH) * step) >>> 1));
		cy   = clamp_q32(view_cy
			+ ((((2 * longint'(row)) - mbe_pkg::HEIGHT) * step) >>> 1));
		x    = cx;
		y    = cy;
		n    = 0;
		gone = 1'b0;
		while (n < mbe_pkg::MAX_ITER && !gone) begin
			x2 = (x * x) >>> mbe_pkg::FRAC_BITS;
			y2 = (y * y) >>> mbe_pkg::FRAC_BITS;
			xy = (x * y) >>> mbe_pkg::FRAC_BITS;
			if (x2 + y2 > view_r2) begin
				gone = 1'b1;
			end else begin
				x = clamp_q32(x2 - y2 + cx);
				y = clamp_q32(2 * xy + cy);
				n++;
			end
		end
		r.iter_count = 8'(n);
		r.escaped    = gone;
		r.red        = gone ? gradient_level(8'(n), 64'd4, 32'h2000_0000) : 8'd0;
		r.green      = gone ? gradient_level(8'(n), 64'd8, 32'h1000_0000) : 8'd0;
		r.blue       = gone ? gradient_level(8'(n), 64'd16, 32'h0800_0000) : 8'd0;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_colour_t want;
		if (!arst_n) begin
			view_cx   = -64'sd9227469;
			view_cy   = 64'sd0;
			view_zoom = 64'sd16777216;
			view_step = 64'sd55924;
			view_r2   = 64'sd1677721600;
			expected_pixels.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					mbe_pkg::REG_CENTER_X:   view_cx   = longint'(signed'(cfg.data));
					mbe_pkg::REG_CENTER_Y:   view_cy   = longint'(signed'(cfg.data));
					mbe_pkg::REG_ZOOM_SCALE: view_zoom = longint'(cfg.data[30:0]);
					mbe_pkg::REG_PIXEL_STEP: view_step = longint'(cfg.data[30:0]);
					mbe_pkg::REG_ESCAPE_R2:  view_r2   = longint'(cfg.data[30:0]);
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result request with no pixel pending");
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("iter_count", want.iter_count, result.iter_count);
					check_field("escaped", 8'(want.escaped), 8'(result.escaped));
					check_field("red", want.red, result.red);
					check_field("green", want.green, result.green);
					check_field("blue", want.blue, result.blue);
				end
			end
			if (pixel.valid && pixel.ready) begin
				expected_pixels.push_back(escape_time(pixel.col, pixel.row));
			end
			outstanding = expected_pixels.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         PHASE_ITEMS      = 190;
	localparam int         LONG_HOLD_CYCLES = 600;
	localparam logic [2:0] FIRST_UNUSED_IDX = 3'd5;
	localparam logic [2:0] LAST_UNUSED_IDX  = 3'd7;

	// A few view points in Q8.24.
	localparam logic [31:0] Q_ZERO       = 32'sd0;
	localparam logic [31:0] Q_DEFAULT_CX = -32'sd9227469;
	localparam logic [31:0] Q_SEVEN_NINE = 32'sd132540006;
	localparam logic [31:0] Q_ELEVEN     = 32'sd184549376;
	localparam logic [30:0] Q_ONE        = 31'd16777216;
	localparam logic [30:0] Q_FOUR       = 31'd67108864;
	localparam logic [30:0] Q_HUNDRED    = 31'd1677721600;
	localparam logic [30:0] Q_PIX_STEP   = 31'd55924;
	localparam logic [30:0] Q31_MAX      = 31'h7FFF_FFFF;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   send_idle_pct;
	int   stall_pct;
	int   hold_requests;

	mbe_pix_if pix_ch();
	mbe_res_if res_ch();
	mbe_cfg_if cfg_ch();

	mandelbrot_escape_time_pixel_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pixel (pix_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	escape_time_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pix_ch),
		.result     (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// Result side. A long hold-off request keeps ready low long enough for the
	// core to fill its output register and stop taking pixels.
	initial begin
		int hold_left;
		int holds_taken;
		hold_left    = 0;
		holds_taken  = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_taken) begin
				holds_taken = hold_requests;
				hold_left   = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Writes every view register plus one index past the list, which the core
	// must ignore. Bit 31 of the unsigned registers is random and must be dropped.
	task automatic set_view(input logic [31:0] cx, input logic [31:0] cy,
		input logic [30:0] zoom, input logic [30:0] pstep, input logic [30:0] r2);
		put_reg(mbe_pkg::REG_CENTER_X, cx);
		put_reg(mbe_pkg::REG_CENTER_Y, cy);
		put_reg(mbe_pkg::REG_ZOOM_SCALE, {1'($urandom), zoom});
		put_reg(mbe_pkg::REG_PIXEL_STEP, {1'($urandom), pstep});
		put_reg(mbe_pkg::REG_ESCAPE_R2, {1'($urandom), r2});
		put_reg(3'($urandom_range(LAST_UNUSED_IDX, FIRST_UNUSED_IDX)), $urandom);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic offer_pixel(input logic [10:0] col, input logic [10:0] row);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.col   <= col;
		pix_ch.row   <= row;
		@(posedge clk);
		while (!pix_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic await_results();
		pix_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	task automatic run_phase(input int mode, input bit long_hold);
		logic [10:0] col;
		logic [10:0] row;
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 60; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 60; end
			default: begin send_idle_pct = 23; stall_pct = 23; end
		endcase
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// Most pixels stay on screen; some use the full coordinate range.
			col = ($urandom_range(99) < 20) ? 11'($urandom)
				: 11'($urandom_range(mbe_pkg::WIDTH - 1));
			row = ($urandom_range(99) < 20) ? 11'($urandom)
				: 11'($urandom_range(mbe_pkg::HEIGHT - 1));
			if (long_hold && i == 20) begin
				hold_requests++;
			end
			offer_pixel(col, row);
		end
		await_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests = 0;
		pix_ch.valid  = 1'b0;
		pix_ch.col    = '0;
		pix_ch.row    = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: the center point never escapes, corners escape early,
		// and off-screen positions extrapolate.
		offer_pixel(11'd400, 11'd300);
		offer_pixel(11'd0, 11'd0);
		offer_pixel(11'd799, 11'd599);
		offer_pixel(11'd2047, 11'd2047);
		offer_pixel(11'd0, 11'd2047);
		offer_pixel(11'd2047, 11'd0);
		offer_pixel(11'd1023, 11'd1024);
		offer_pixel(11'd200, 11'd300);
		offer_pixel(11'd600, 11'd150);
		await_results();

		// Zero escape radius: escape on the first test, except at the origin.
		set_view(Q_DEFAULT_CX, Q_ZERO, Q_ONE, Q_PIX_STEP, 31'd0);
		offer_pixel(11'd400, 11'd300);
		offer_pixel(11'd13, 11'd577);
		await_results();
		set_view(Q_ZERO, Q_ZERO, 31'd0, Q_PIX_STEP, 31'd0);
		offer_pixel(11'd5, 11'd5);
		await_results();

		// With zero zoom every pixel maps to the center; these centers pass the
		// first test but overflow the update, which must saturate.
		set_view(Q_ELEVEN, Q_ZERO, 31'd0, Q_PIX_STEP, Q31_MAX);
		offer_pixel(11'd1, 11'd2);
		await_results();
		set_view(Q_SEVEN_NINE, Q_SEVEN_NINE, 31'd0, Q_PIX_STEP, Q31_MAX);
		offer_pixel(11'd3, 11'd4);
		await_results();
		set_view(Q_SEVEN_NINE, -Q_SEVEN_NINE, 31'd0, Q_PIX_STEP, Q31_MAX);
		offer_pixel(11'd5, 11'd6);
		await_results();

		// Largest step: the mapping itself saturates.
		set_view(32'h7FFF_FFFF, 32'h8000_0000, Q31_MAX, Q31_MAX, Q31_MAX);
		offer_pixel(11'd0, 11'd0);
		offer_pixel(11'd2047, 11'd2047);
		offer_pixel(11'd400, 11'd300);
		await_results();

		set_view(Q_DEFAULT_CX, Q_ZERO, Q_ONE, Q_PIX_STEP, Q_HUNDRED);
		run_phase(0, 1'b0);

		// Near the boundary, zoomed in, radius 2.
		set_view(-32'sd12476262, 32'sd2211647, 31'd262144, Q_PIX_STEP, Q_FOUR);
		run_phase(1, 1'b0);

		set_view(32'($urandom_range(41943040)) - 32'sd33554432,
			32'($urandom_range(33554432)) - 32'sd16777216,
			31'($urandom_range(33554432, 262144)), Q_PIX_STEP,
			31'($urandom_range(Q_HUNDRED, Q_FOUR)));
		run_phase(2, 1'b1);

		set_view(32'h8000_0000, 32'h7FFF_FFFF, Q31_MAX, Q31_MAX, Q31_MAX);
		run_phase(3, 1'b0);

		set_view(Q_DEFAULT_CX, Q_ZERO, Q_ONE, Q_PIX_STEP, 31'd0);
		run_phase(0, 1'b0);

		set_view($urandom, $urandom, 31'($urandom), 31'($urandom), 31'($urandom));
		run_phase(1, 1'b0);

		set_view(Q_DEFAULT_CX, Q_ZERO, Q_ONE, Q_PIX_STEP, Q31_MAX);
		run_phase(3, 1'b0);

		set_view(-32'sd12582912, 32'sd1677722, 31'd2097152, Q_PIX_STEP, Q_FOUR);
		run_phase(2, 1'b0);

		repeat (250) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
